/* design/adam_weight_update_top_defines.svh */
// assertion macros used by the checker file of the adam weight update block
// depends on nothing; included by design/awu_checker.sv
`ifndef ADAM_WEIGHT_UPDATE_TOP_DEFINES_SVH
`define ADAM_WEIGHT_UPDATE_TOP_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define AWU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("awu assertion failed");

// next-cycle implication, quiet while reset is high
`define AWU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("awu assertion failed");

// next-cycle implication that also holds across reset
`define AWU_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("awu assertion failed");

`endif

/* design/awu_pkg.sv */
// shared types, constants and binary32 arithmetic helpers for the adam weight update
// no dependencies; imported by the top, square root and divider modules and the testbench
`default_nettype none

package awu_pkg;

   localparam logic [31:0] QNAN   = 32'h7FC0_0000;
   localparam logic [31:0] FP_ONE = 32'h3F80_0000;

   localparam int SQRT_STAGES = 14;   // one setup stage, then two root bits a stage
   localparam int DIV_STAGES  = 15;   // one setup stage, then two quotient bits a stage

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEARNING_RATE,
      CSR_FIRST_MOMENT_DECAY,
      CSR_SECOND_MOMENT_DECAY,
      CSR_STABILITY_EPSILON,
      CSR_WEIGHT_DECAY
   } csr_index_type;

   // unrounded result: sig bit 47 has weight 2^(exp-127)
   typedef struct packed {
      logic               spec;
      logic [31:0]        spec_val;
      logic               sign;
      logic signed [11:0] exp;
      logic [47:0]        sig;
   } mid_type;

   function automatic logic is_nan(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
   endfunction

   function automatic logic [7:0] eff_exp(input logic [31:0] x);
      return (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
   endfunction

   function automatic logic [4:0] lzc24(input logic [23:0] x);
      logic [4:0] n;
      logic       found;
      n = 5'd0;
      found = 1'b0;
      for (int i = 23; i >= 0; i--) begin
         if (!found && x[i]) begin
            n = 5'(23 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // sig[26] is the leading one, sig[0] folds in sticky; round to nearest even
   function automatic logic [31:0] fp_round(input logic sign, input logic signed [11:0] exp,
                                            input logic [26:0] sig);
      logic [26:0] sh;
      logic [11:0] amt;
      logic [26:0] mask;
      logic [7:0]  ebias;
      logic [24:0] man;
      logic        rnd;
      logic [30:0] mag;
      sh = sig;
      ebias = 8'd0;
      amt = 12'd0;
      mask = 27'd0;
      if (exp >= 12'sd255) begin
         return {sign, 8'hFF, 23'd0};
      end
      if (exp <= 12'sd0) begin
         // subnormal range: denormalize with sticky
         amt = 12'd1 - $unsigned(exp);
         if (amt > 12'd27) amt = 12'd27;
         mask = (27'd1 << amt) - 27'd1;
         sh = (sig >> amt) | {26'd0, |(sig & mask)};
      end else begin
         ebias = 8'(exp - 12'sd1);
      end
      rnd = sh[2] & (sh[1] | sh[0] | sh[3]);
      man = {1'b0, sh[26:3]} + {24'd0, rnd};
      // mantissa carry ripples into the exponent field
      mag = {ebias, 23'd0} + {6'd0, man};
      return {sign, mag};
   endfunction

   function automatic logic [31:0] fp_norm(input mid_type m);
      logic [5:0]  lz;
      logic [47:0] x;
      logic        found;
      lz = 6'd0;
      found = 1'b0;
      if (m.spec) return m.spec_val;
      if (m.sig == 48'd0) return {m.sign, 31'd0};
      for (int i = 47; i >= 0; i--) begin
         if (!found && m.sig[i]) begin
            lz = 6'(47 - i);
            found = 1'b1;
         end
      end
      x = m.sig << lz;
      return fp_round(m.sign, m.exp - $signed({6'd0, lz}), {x[47:22], |x[21:0]});
   endfunction

   function automatic mid_type fp_mul_a(input logic [31:0] a, input logic [31:0] b);
      mid_type     m;
      logic [23:0] ma;
      logic [23:0] mb;
      logic        az;
      logic        bz;
      m = '0;
      az = (a[30:0] == 31'd0);
      bz = (b[30:0] == 31'd0);
      m.sign = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b) || (is_inf(a) && bz) || (is_inf(b) && az)) begin
         m.spec = 1'b1;
         m.spec_val = QNAN;
      end else if (is_inf(a) || is_inf(b)) begin
         m.spec = 1'b1;
         m.spec_val = {m.sign, 8'hFF, 23'd0};
      end else begin
         ma = {a[30:23] != 8'd0, a[22:0]};
         mb = {b[30:23] != 8'd0, b[22:0]};
         m.sig = ma * mb;
         m.exp = $signed({4'd0, eff_exp(a)}) + $signed({4'd0, eff_exp(b)}) - 12'sd126;
      end
      return m;
   endfunction

   function automatic mid_type fp_add_a(input logic [31:0] a, input logic [31:0] b);
      mid_type     m;
      logic [31:0] x;
      logic [31:0] y;
      logic [7:0]  d;
      logic [47:0] xs;
      logic [47:0] y0;
      logic [47:0] ys;
      logic [47:0] sum;
      m = '0;
      x = a;
      y = b;
      ys = 48'd0;
      if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31]))) begin
         m.spec = 1'b1;
         m.spec_val = QNAN;
      end else if (is_inf(a)) begin
         m.spec = 1'b1;
         m.spec_val = a;
      end else if (is_inf(b)) begin
         m.spec = 1'b1;
         m.spec_val = b;
      end else begin
         if (a[30:0] < b[30:0]) begin
            x = b;
            y = a;
         end
         d = eff_exp(x) - eff_exp(y);
         xs = {1'b0, x[30:23] != 8'd0, x[22:0], 23'd0};
         y0 = {1'b0, y[30:23] != 8'd0, y[22:0], 23'd0};
         if (d > 8'd47) begin
            ys = {47'd0, |y0};
         end else begin
            ys = (y0 >> d) | {47'd0, |(y0 & ((48'd1 << d) - 48'd1))};
         end
         sum = (x[31] == y[31]) ? xs + ys : xs - ys;
         m.sig = sum;
         // exact cancellation gives +0 unless both operands are negative
         m.sign = (sum == 48'd0) ? (a[31] & b[31]) : x[31];
         m.exp = $signed({4'd0, eff_exp(x)}) + 12'sd1;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

/* design/adam_weight_update_top.sv */
// adam optimizer element update, binary32, 48-stage elastic pipeline
// depends on awu_pkg, awu_sqrt and awu_div
//
//   channel   direction   handshake           payload
//   req       in          req_valid/ready     weight, gradient, moments, first_of_pass
//   rsp       out         rsp_valid/ready     weight, moments, step count
//   csr       in          csr_write_enable    index, 32-bit data
//
// one request per cycle sustained while results are taken; a result is offered once it
// has passed the input register, eight multiply or add units of two stages each, and the
// square root (14 stages) and divider (15 stages), each followed by a rounding stage
// every stage holds a valid bit and advances when the stage after it is empty or moving,
// so requests keep flowing into bubbles while a result waits on rsp_ready
// reset clears the valid bits and the step counter and loads the csr defaults
`default_nettype none

module adam_weight_update_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [31:0]                       req_weight_in,
   input  logic [31:0]                       req_gradient,
   input  logic [31:0]                       req_moment1_in,
   input  logic [31:0]                       req_moment2_in,
   input  logic                              req_first_of_pass,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [31:0]                       rsp_weight_out,
   output logic [31:0]                       rsp_moment1_out,
   output logic [31:0]                       rsp_moment2_out,
   output logic [31:0]                       rsp_step_count,
   input  logic                              csr_write_enable,
   input  logic [awu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                       csr_write_data
);
   import awu_pkg::*;

   localparam int S_IN     = 0;
   localparam int S_MUL1   = 1;
   localparam int S_PROD1  = 2;
   localparam int S_MUL2   = 3;
   localparam int S_PROD2  = 4;
   localparam int S_SUM1   = 5;
   localparam int S_M1N    = 6;
   localparam int S_SUM2   = 7;
   localparam int S_M2N    = 8;
   localparam int S_SQRT   = 9;
   localparam int S_SQ     = S_SQRT + SQRT_STAGES;
   localparam int S_DEN_A  = S_SQ + 1;
   localparam int S_DEN    = S_SQ + 2;
   localparam int S_DIV    = S_SQ + 3;
   localparam int S_QT     = S_DIV + DIV_STAGES;
   localparam int S_UPD_A  = S_QT + 1;
   localparam int S_UPD    = S_QT + 2;
   localparam int S_DLT_A  = S_QT + 3;
   localparam int S_DLT    = S_QT + 4;
   localparam int S_WN_A   = S_QT + 5;
   localparam int S_OUT    = S_QT + 6;
   localparam int NST      = S_OUT + 1;

   typedef struct packed {
      logic [31:0] w;
      logic [31:0] g;
      logic [31:0] m1;
      logic [31:0] m2;
      logic [31:0] step;
      logic [31:0] p1;
      logic [31:0] p2;
      logic [31:0] dw;
      logic [31:0] m1n;
      logic [31:0] m2n;
   } carry_type;

   // csr registers
   logic [31:0] lr_ff;
   logic [31:0] beta1_ff;
   logic [31:0] beta2_ff;
   logic [31:0] eps_ff;
   logic [31:0] decay_ff;
   logic [31:0] step_ff;

   logic [NST-1:0] v_ff;
   logic [NST-1:0] v_in;
   logic [NST-1:0] en;
   carry_type      c_ff [NST];
   carry_type      c_in [NST];

   mid_type     s1_p1_ff;
   mid_type     s1_p2_ff;
   mid_type     s1_t1_ff;
   mid_type     s1_t2_ff;
   mid_type     s1_dw_ff;
   logic [31:0] s2_t1_ff;
   logic [31:0] s2_t2_ff;
   mid_type     s3_q1_ff;
   mid_type     s3_r_ff;
   logic [31:0] s4_q1_ff;
   logic [31:0] s4_r_ff;
   mid_type     s5_m1_ff;
   mid_type     s5_r2_ff;
   logic [31:0] s6_r2_ff;
   mid_type     s7_m2_ff;
   logic [31:0] sq_ff;
   mid_type     den_a_ff;
   logic [31:0] den_ff;
   logic [31:0] qt_ff;
   mid_type     upd_a_ff;
   logic [31:0] upd_ff;
   mid_type     dlt_a_ff;
   logic [31:0] dlt_ff;
   mid_type     wn_a_ff;
   logic [31:0] wn_ff;

   mid_type sqrt_res;
   mid_type div_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff <= 32'h3A83_126F;
         beta1_ff <= 32'h3F66_6666;
         beta2_ff <= 32'h3F7F_BE77;
         eps_ff <= 32'h322B_CC77;
         decay_ff <= 32'h0000_0000;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEARNING_RATE:       lr_ff <= csr_write_data;
            CSR_FIRST_MOMENT_DECAY:  beta1_ff <= csr_write_data;
            CSR_SECOND_MOMENT_DECAY: beta2_ff <= csr_write_data;
            CSR_STABILITY_EPSILON:   eps_ff <= csr_write_data;
            CSR_WEIGHT_DECAY:        decay_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // a stage moves when it is empty or the stage after it moves
   always_comb begin
      en[NST-1] = !v_ff[NST-1] || rsp_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign v_in = {v_ff[NST-2:0], req_valid};
   assign req_ready = en[S_IN];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         step_ff <= 32'd0;
      end else begin
         v_ff <= (en & v_in) | (~en & v_ff);
         if (req_valid && req_ready) step_ff <= c_in[S_IN].step;
      end
   end

   always_comb begin
      c_in[S_IN] = '0;
      c_in[S_IN].w = req_weight_in;
      c_in[S_IN].g = req_gradient;
      c_in[S_IN].m1 = req_moment1_in;
      c_in[S_IN].m2 = req_moment2_in;
      c_in[S_IN].step = step_ff + {31'd0, req_first_of_pass};
      for (int k = 1; k < NST; k++) begin
         c_in[k] = c_ff[k-1];
      end
      c_in[S_PROD1].p1 = fp_norm(s1_p1_ff);
      c_in[S_PROD1].p2 = fp_norm(s1_p2_ff);
      c_in[S_PROD1].dw = fp_norm(s1_dw_ff);
      c_in[S_M1N].m1n = fp_norm(s5_m1_ff);
      c_in[S_M2N].m2n = fp_norm(s7_m2_ff);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (en[k]) c_ff[k] <= c_in[k];
      end
      if (en[S_MUL1]) begin
         s1_p1_ff <= fp_mul_a(beta1_ff, c_ff[S_IN].m1);
         s1_p2_ff <= fp_mul_a(beta2_ff, c_ff[S_IN].m2);
         s1_t1_ff <= fp_add_a(FP_ONE, {~beta1_ff[31], beta1_ff[30:0]});
         s1_t2_ff <= fp_add_a(FP_ONE, {~beta2_ff[31], beta2_ff[30:0]});
         s1_dw_ff <= fp_mul_a(decay_ff, c_ff[S_IN].w);
      end
      if (en[S_PROD1]) begin
         s2_t1_ff <= fp_norm(s1_t1_ff);
         s2_t2_ff <= fp_norm(s1_t2_ff);
      end
      if (en[S_MUL2]) begin
         s3_q1_ff <= fp_mul_a(s2_t1_ff, c_ff[S_PROD1].g);
         s3_r_ff <= fp_mul_a(s2_t2_ff, c_ff[S_PROD1].g);
      end
      if (en[S_PROD2]) begin
         s4_q1_ff <= fp_norm(s3_q1_ff);
         s4_r_ff <= fp_norm(s3_r_ff);
      end
      if (en[S_SUM1]) begin
         s5_m1_ff <= fp_add_a(c_ff[S_PROD2].p1, s4_q1_ff);
         s5_r2_ff <= fp_mul_a(s4_r_ff, c_ff[S_PROD2].g);
      end
      if (en[S_M1N]) s6_r2_ff <= fp_norm(s5_r2_ff);
      if (en[S_SUM2]) s7_m2_ff <= fp_add_a(c_ff[S_M1N].p2, s6_r2_ff);
      if (en[S_SQ]) sq_ff <= fp_norm(sqrt_res);
      if (en[S_DEN_A]) den_a_ff <= fp_add_a(sq_ff, eps_ff);
      if (en[S_DEN]) den_ff <= fp_norm(den_a_ff);
      if (en[S_QT]) qt_ff <= fp_norm(div_res);
      if (en[S_UPD_A]) upd_a_ff <= fp_add_a(qt_ff, c_ff[S_QT].dw);
      if (en[S_UPD]) upd_ff <= fp_norm(upd_a_ff);
      if (en[S_DLT_A]) dlt_a_ff <= fp_mul_a({~lr_ff[31], lr_ff[30:0]}, upd_ff);
      if (en[S_DLT]) dlt_ff <= fp_norm(dlt_a_ff);
      if (en[S_WN_A]) wn_a_ff <= fp_add_a(c_ff[S_DLT].w, dlt_ff);
      if (en[S_OUT]) wn_ff <= fp_norm(wn_a_ff);
   end

   awu_sqrt u_sqrt (
      .clock    (clock),
      .stage_en (en[S_SQRT +: SQRT_STAGES]),
      .operand  (c_ff[S_M2N].m2n),
      .result   (sqrt_res)
   );

   awu_div u_div (
      .clock    (clock),
      .stage_en (en[S_DIV +: DIV_STAGES]),
      .dividend (c_ff[S_DEN].m1n),
      .divisor  (den_ff),
      .result   (div_res)
   );

   assign rsp_valid = v_ff[S_OUT];
   assign rsp_weight_out = wn_ff;
   assign rsp_moment1_out = c_ff[S_OUT].m1n;
   assign rsp_moment2_out = c_ff[S_OUT].m2n;
   assign rsp_step_count = c_ff[S_OUT].step;

endmodule

`default_nettype wire

/* design/awu_sqrt.sv */
// pipelined binary32 square root, two root bits per stage, unrounded result out
// depends on awu_pkg; stage enables come from the top level pipeline control
`default_nettype none

module awu_sqrt (
   input  logic                                 clock,
   input  logic [awu_pkg::SQRT_STAGES-1:0]      stage_en,
   input  logic [31:0]                          operand,
   output awu_pkg::mid_type                     result
);
   import awu_pkg::*;

   typedef struct packed {
      logic               spec;
      logic [31:0]        spec_val;
      logic signed [11:0] exp;
      logic [51:0]        rad;
      logic [27:0]        rem;
      logic [25:0]        root;
   } sqrt_stage_type;

   sqrt_stage_type st_ff [SQRT_STAGES];
   sqrt_stage_type st_in [SQRT_STAGES];

   function automatic sqrt_stage_type sqrt_iter(input sqrt_stage_type s);
      sqrt_stage_type r;
      logic [27:0]    rem_t;
      logic [27:0]    trial;
      r = s;
      rem_t = {s.rem[25:0], s.rad[51:50]};
      trial = {1'b0, s.root[24:0], 2'b01};
      if (rem_t >= trial) begin
         r.rem = rem_t - trial;
         r.root = {s.root[24:0], 1'b1};
      end else begin
         r.rem = rem_t;
         r.root = {s.root[24:0], 1'b0};
      end
      r.rad = {s.rad[49:0], 2'b00};
      return r;
   endfunction

   logic [23:0]        m24;
   logic [4:0]         lz;
   logic [23:0]        mn;
   logic [24:0]        n25;
   logic signed [11:0] eu;

   always_comb begin
      st_in[0] = '0;
      m24 = {operand[30:23] != 8'd0, operand[22:0]};
      lz = lzc24(m24);
      mn = m24 << lz;
      n25 = {1'b0, mn};
      eu = $signed({4'd0, eff_exp(operand)}) - $signed({7'd0, lz}) - 12'sd127;
      if (is_nan(operand)) begin
         st_in[0].spec = 1'b1;
         st_in[0].spec_val = QNAN;
      end else if (operand[30:0] == 31'd0) begin
         st_in[0].spec = 1'b1;
         st_in[0].spec_val = operand;
      end else if (operand[31]) begin
         st_in[0].spec = 1'b1;
         st_in[0].spec_val = QNAN;
      end else if (operand[30:23] == 8'hFF) begin
         st_in[0].spec = 1'b1;
         st_in[0].spec_val = operand;
      end else begin
         // make the exponent even so the root exponent is exact
         if (eu[0]) begin
            n25 = {mn, 1'b0};
            eu = eu - 12'sd1;
         end
         st_in[0].rad = {n25, 27'd0};
         st_in[0].exp = (eu >>> 1) + 12'sd127;
      end
      for (int k = 1; k < SQRT_STAGES; k++) begin
         st_in[k] = sqrt_iter(sqrt_iter(st_ff[k-1]));
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
         if (stage_en[k]) st_ff[k] <= st_in[k];
      end
   end

   always_comb begin
      result.spec = st_ff[SQRT_STAGES-1].spec;
      result.spec_val = st_ff[SQRT_STAGES-1].spec_val;
      result.sign = 1'b0;
      result.exp = st_ff[SQRT_STAGES-1].exp;
      result.sig = {st_ff[SQRT_STAGES-1].root, |st_ff[SQRT_STAGES-1].rem, 21'd0};
   end

endmodule

`default_nettype wire

/* design/awu_div.sv */
// pipelined binary32 divider, restoring, two quotient bits per stage, unrounded result
// depends on awu_pkg; stage enables come from the top level pipeline control
`default_nettype none

module awu_div (
   input  logic                                 clock,
   input  logic [awu_pkg::DIV_STAGES-1:0]       stage_en,
   input  logic [31:0]                          dividend,
   input  logic [31:0]                          divisor,
   output awu_pkg::mid_type                     result
);
   import awu_pkg::*;

   typedef struct packed {
      logic               spec;
      logic [31:0]        spec_val;
      logic               sign;
      logic signed [11:0] exp;
      logic [24:0]        rem;
      logic [27:0]        quo;
      logic [23:0]        dvs;
   } div_stage_type;

   div_stage_type st_ff [DIV_STAGES];
   div_stage_type st_in [DIV_STAGES];

   function automatic div_stage_type div_iter(input div_stage_type s);
      div_stage_type r;
      logic [24:0]   diff;
      r = s;
      diff = s.rem;
      if (s.rem >= {1'b0, s.dvs}) begin
         diff = s.rem - {1'b0, s.dvs};
         r.quo = {s.quo[26:0], 1'b1};
      end else begin
         r.quo = {s.quo[26:0], 1'b0};
      end
      r.rem = {diff[23:0], 1'b0};
      return r;
   endfunction

   logic [23:0] ma;
   logic [23:0] mb;
   logic [4:0]  lza;
   logic [4:0]  lzb;
   logic        az;
   logic        bz;
   logic        sgn;

   always_comb begin
      st_in[0] = '0;
      ma = {dividend[30:23] != 8'd0, dividend[22:0]};
      mb = {divisor[30:23] != 8'd0, divisor[22:0]};
      lza = lzc24(ma);
      lzb = lzc24(mb);
      az = (dividend[30:0] == 31'd0);
      bz = (divisor[30:0] == 31'd0);
      sgn = dividend[31] ^ divisor[31];
      st_in[0].sign = sgn;
      if (is_nan(dividend) || is_nan(divisor) || (az && bz)
          || (is_inf(dividend) && is_inf(divisor))) begin
         st_in[0].spec = 1'b1;
         st_in[0].spec_val = QNAN;
      end else if (is_inf(dividend) || bz) begin
         st_in[0].spec = 1'b1;
         st_in[0].spec_val = {sgn, 8'hFF, 23'd0};
      end else if (az || is_inf(divisor)) begin
         st_in[0].spec = 1'b1;
         st_in[0].spec_val = {sgn, 31'd0};
      end else begin
         // both significands normalized to 1.x, quotient lands in (0.5, 2)
         st_in[0].rem = {1'b0, ma << lza};
         st_in[0].dvs = mb << lzb;
         st_in[0].exp = ($signed({4'd0, eff_exp(dividend)}) - $signed({7'd0, lza}))
                      - ($signed({4'd0, eff_exp(divisor)}) - $signed({7'd0, lzb}))
                      + 12'sd127;
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
         st_in[k] = div_iter(div_iter(st_ff[k-1]));
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (stage_en[k]) st_ff[k] <= st_in[k];
      end
   end

   always_comb begin
      result.spec = st_ff[DIV_STAGES-1].spec;
      result.spec_val = st_ff[DIV_STAGES-1].spec_val;
      result.sign = st_ff[DIV_STAGES-1].sign;
      result.exp = st_ff[DIV_STAGES-1].exp;
      result.sig = {st_ff[DIV_STAGES-1].quo, |st_ff[DIV_STAGES-1].rem, 19'd0};
   end

endmodule

`default_nettype wire

/* design/awu_checker.sv */
// port-level checks for the adam weight update top, attached by bind
// depends on adam_weight_update_top_defines.svh
`default_nettype none

`include "adam_weight_update_top_defines.svh"

module awu_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_ready,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [31:0]                       rsp_weight_out,
   input  logic [31:0]                       rsp_moment1_out,
   input  logic [31:0]                       rsp_moment2_out,
   input  logic [31:0]                       rsp_step_count
);

   logic         rsp_stall;
   logic [127:0] rsp_payload;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_weight_out, rsp_moment1_out, rsp_moment2_out, rsp_step_count};

   // a stalled result keeps its payload
   `AWU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // reset empties the pipeline and opens the request side
   `AWU_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && req_ready)

   // a free output stage lets every stage move, so a request is always taken
   `AWU_ASSERT_SAME(a_ready_when_free, clock, reset, !rsp_valid || rsp_ready, req_ready)

endmodule

bind adam_weight_update_top awu_checker u_awu_checker (.*);

`default_nettype wire

/* test/adam_weight_update_top_test.sv */
// self-checking testbench for adam_weight_update_top, binary32 adam step per request
// depends on awu_pkg and the design files; predicts results with its own float routines
`default_nettype none

module adam_weight_update_top_test;
   import awu_pkg::*;

   localparam bit [31:0] CANON_NAN = 32'h7FC0_0000;
   localparam bit [31:0] POS_INF   = 32'h7F80_0000;
   localparam bit [31:0] ONE_BITS  = 32'h3F80_0000;

   typedef struct {
      bit [31:0] weight;
      bit [31:0] grad;
      bit [31:0] mom1;
      bit [31:0] mom2;
      bit        first;
   } element_type;

   typedef struct {
      bit [31:0] weight;
      bit [31:0] mom1;
      bit [31:0] mom2;
      bit [31:0] steps;
   } update_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [31:0]            req_weight_in;
   logic [31:0]            req_gradient;
   logic [31:0]            req_moment1_in;
   logic [31:0]            req_moment2_in;
   logic                   req_first_of_pass;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [31:0]            rsp_weight_out;
   logic [31:0]            rsp_moment1_out;
   logic [31:0]            rsp_moment2_out;
   logic [31:0]            rsp_step_count;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_write_data;

   element_type pending_elements[$];
   update_type  expected_updates[$];
   bit [31:0] lr_bits;
   bit [31:0] beta1_bits;
   bit [31:0] beta2_bits;
   bit [31:0] eps_bits;
   bit [31:0] decay_bits;
   bit [31:0] step_total;
   int        error_count;
   int        updates_seen;
   int        send_gap;
   int        recv_hold;
   bit        steady_flow;

   adam_weight_update_top dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------- binary32 arithmetic, via exact double intermediates

   function automatic bit f_nan(bit [31:0] x);
      return x[30:23] == 8'hFF && x[22:0] != 0;
   endfunction

   function automatic bit f_inf(bit [31:0] x);
      return x[30:0] == POS_INF[30:0];
   endfunction

   function automatic bit f_zero(bit [31:0] x);
      return x[30:0] == 0;
   endfunction

   function automatic real to_real(bit [31:0] x);
      int        ex;
      bit [23:0] mant;
      if (x[30:0] == 0) return $bitstoreal({x[31], 63'd0});
      if (x[30:23] == 0) begin
         ex = -126;
         mant = {1'b0, x[22:0]};
         while (!mant[23]) begin
            mant = mant << 1;
            ex--;
         end
      end else begin
         ex = int'(x[30:23]) - 127;
         mant = {1'b1, x[22:0]};
      end
      return $bitstoreal({x[31], 11'(ex + 1023), mant[22:0], 29'd0});
   endfunction

   // round a double to binary32, nearest even, subnormals kept
   function automatic bit [31:0] to_single(real r);
      bit [63:0] d;
      bit [63:0] mant;
      bit [63:0] q;
      bit [63:0] packed_val;
      int        ex;
      int        sh;
      bit        guard;
      bit        sticky;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? CANON_NAN : {d[63], POS_INF[30:0]};
      if (d[62:52] == 0) return {d[63], 31'd0};
      mant = {11'd0, 1'b1, d[51:0]};
      ex = int'(d[62:52]) - 1023;
      sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
      if (sh > 60) begin
         q = 0;
         guard = 0;
         sticky = 1;
      end else begin
         q = mant >> sh;
         guard = mant[sh-1];
         sticky = (mant & ((64'd1 << (sh - 1)) - 64'd1)) != 0;
      end
      if (guard && (sticky || q[0])) q++;
      packed_val = (ex >= -126) ? (64'(ex + 126) << 23) + q : q;
      if (packed_val >= 64'h7F80_0000) return {d[63], POS_INF[30:0]};
      return {d[63], packed_val[30:0]};
   endfunction

   function automatic bit [31:0] f_mul(bit [31:0] a, bit [31:0] b);
      if (f_nan(a) || f_nan(b) || (f_inf(a) && f_zero(b)) || (f_inf(b) && f_zero(a)))
         return CANON_NAN;
      if (f_inf(a) || f_inf(b)) return {a[31] ^ b[31], POS_INF[30:0]};
      return to_single(to_real(a) * to_real(b));
   endfunction

   function automatic bit [31:0] f_add(bit [31:0] a, bit [31:0] b);
      if (f_nan(a) || f_nan(b) || (f_inf(a) && f_inf(b) && a[31] != b[31])) return CANON_NAN;
      if (f_inf(a)) return a;
      if (f_inf(b)) return b;
      return to_single(to_real(a) + to_real(b));
   endfunction

   function automatic bit [31:0] f_div(bit [31:0] a, bit [31:0] b);
      if (f_nan(a) || f_nan(b) || (f_inf(a) && f_inf(b)) || (f_zero(a) && f_zero(b)))
         return CANON_NAN;
      if (f_inf(a) || f_zero(b)) return {a[31] ^ b[31], POS_INF[30:0]};
      if (f_inf(b)) return {a[31] ^ b[31], 31'd0};
      return to_single(to_real(a) / to_real(b));
   endfunction

   function automatic bit [31:0] f_sqrt(bit [31:0] a);
      if (f_nan(a)) return CANON_NAN;
      if (f_zero(a)) return a;
      if (a[31]) return CANON_NAN;
      if (f_inf(a)) return a;
      return to_single($sqrt(to_real(a)));
   endfunction

   function automatic bit [31:0] canon(bit [31:0] x);
      return f_nan(x) ? CANON_NAN : x;
   endfunction

   // one adam step on the current register settings; bumps the pass counter on a first_of_pass element
   function automatic update_type adam_step(element_type e);
      update_type u;
      bit [31:0]  m1n;
      bit [31:0]  m2n;
      bit [31:0]  denom;
      bit [31:0]  upd;
      if (e.first) step_total = step_total + 1;
      m1n = f_add(f_mul(beta1_bits, e.mom1), f_mul(f_add(ONE_BITS, beta1_bits ^ 32'h8000_0000),
                  e.grad));
      m2n = f_add(f_mul(beta2_bits, e.mom2),
                  f_mul(f_mul(f_add(ONE_BITS, beta2_bits ^ 32'h8000_0000), e.grad), e.grad));
      denom = f_add(f_sqrt(m2n), eps_bits);
      upd = f_add(f_div(m1n, denom), f_mul(decay_bits, e.weight));
      u.weight = canon(f_add(e.weight, f_mul(lr_bits ^ 32'h8000_0000, upd)));
      u.mom1 = canon(m1n);
      u.mom2 = canon(m2n);
      u.steps = step_total;
      return u;
   endfunction

   // ---------------- stimulus helpers

   function automatic bit [31:0] odd_float();
      case ($urandom_range(0, 9))
         0: return {1'($urandom), 31'd0};
         1: return {1'($urandom), POS_INF[30:0]};
         2: return {1'($urandom), 8'hFF, 23'($urandom | 1)};
         3: return {1'($urandom), 8'h00, 23'($urandom)};
         4: return {1'($urandom), 31'h7F7F_FFFF};
         5: return {1'($urandom), 8'($urandom_range(1, 254)), 23'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic bit [31:0] sane_float(bit positive);
      return {positive ? 1'b0 : 1'($urandom), 8'($urandom_range(100, 132)), 23'($urandom)};
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic queue_element(bit [31:0] w, bit [31:0] g, bit [31:0] m1, bit [31:0] m2,
                                bit first);
      element_type e;
      e.weight = w;
      e.grad = g;
      e.mom1 = m1;
      e.mom2 = m2;
      e.first = first;
      pending_elements.push_back(e);
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 75)
            queue_element(sane_float(0), sane_float(0), sane_float(0), sane_float(1),
                          $urandom_range(0, 9) == 0);
         else
            queue_element(odd_float(), odd_float(), odd_float(), odd_float(), 1'($urandom));
      end
   endtask

   task automatic write_csr(csr_index_type idx, bit [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_LEARNING_RATE:       lr_bits = value;
         CSR_FIRST_MOMENT_DECAY:  beta1_bits = value;
         CSR_SECOND_MOMENT_DECAY: beta2_bits = value;
         CSR_STABILITY_EPSILON:   eps_bits = value;
         CSR_WEIGHT_DECAY:        decay_bits = value;
         default: ;
      endcase
   endtask

   task automatic set_registers(bit [31:0] lr, bit [31:0] b1, bit [31:0] b2, bit [31:0] eps,
                                bit [31:0] dec);
      write_csr(CSR_LEARNING_RATE, lr);
      write_csr(CSR_FIRST_MOMENT_DECAY, b1);
      write_csr(CSR_SECOND_MOMENT_DECAY, b2);
      write_csr(CSR_STABILITY_EPSILON, eps);
      write_csr(CSR_WEIGHT_DECAY, dec);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // waits until every queued element is sent and every update is back, then idles before returning
   task automatic drain();
      while (pending_elements.size() != 0 || req_valid || expected_updates.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // ---------------- request driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            expected_updates.push_back(adam_step('{req_weight_in, req_gradient, req_moment1_in,
                                                   req_moment2_in, req_first_of_pass}));
         if (!(req_valid && !req_ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_elements.size() != 0) begin
               element_type e;
               e = pending_elements.pop_front();
               req_valid <= 1'b1;
               req_weight_in <= e.weight;
               req_gradient <= e.grad;
               req_moment1_in <= e.mom1;
               req_moment2_in <= e.mom2;
               req_first_of_pass <= e.first;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- result monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_updates.size() == 0) begin
               $error("update with nothing expected: weight %h", rsp_weight_out);
               error_count++;
            end else begin
               update_type u;
               u = expected_updates.pop_front();
               if (rsp_weight_out !== u.weight) begin
                  $error("weight_out expected %h actual %h", u.weight, rsp_weight_out);
                  error_count++;
               end
               if (rsp_moment1_out !== u.mom1) begin
                  $error("moment1_out expected %h actual %h", u.mom1, rsp_moment1_out);
                  error_count++;
               end
               if (rsp_moment2_out !== u.mom2) begin
                  $error("moment2_out expected %h actual %h", u.mom2, rsp_moment2_out);
                  error_count++;
               end
               if (rsp_step_count !== u.steps) begin
                  $error("step_count expected %h actual %h", u.steps, rsp_step_count);
                  error_count++;
               end
            end
            updates_seen++;
            // long back-pressure on the result side
            if (updates_seen == 300) recv_hold = 250;
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_ready <= 1'b0;
         end else if (steady_flow || $urandom_range(0, 99) < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            recv_hold = pick_gap();
            rsp_ready <= 1'b0;
         end
      end
   end

   // ---------------- sequence

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_weight_in = '0;
      req_gradient = '0;
      req_moment1_in = '0;
      req_moment2_in = '0;
      req_first_of_pass = 1'b0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      lr_bits = 32'h3A83_126F;
      beta1_bits = 32'h3F66_6666;
      beta2_bits = 32'h3F7F_BE77;
      eps_bits = 32'h322B_CC77;
      decay_bits = 32'h0;
      step_total = 0;
      error_count = 0;
      updates_seen = 0;
      steady_flow = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed corners on the reset settings
      queue_element(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
      queue_element(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      queue_element(32'h3F80_0000, 32'h3F00_0000, 32'h3DCC_CCCD, 32'h3C23_D70A, 1'b0);
      queue_element(32'h7F80_0000, 32'h3F80_0000, 32'h0, 32'h0, 1'b0);
      queue_element(32'hFF80_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7F80_0000, 1'b1);
      queue_element(32'h3F80_0000, 32'h0, 32'h3F80_0000, 32'hBF80_0000, 1'b0); // negative m2
      queue_element(32'h3F80_0000, 32'h8000_0000, 32'h0, 32'h8000_0000, 1'b0); // m2 is -0
      queue_element(32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF, 32'h0000_0001, 1'b0);
      queue_element(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1);
      queue_element(32'hFF7F_FFFF, 32'hFF7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 1'b0);
      queue_element(32'h7FC0_0001, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b0);
      queue_element(32'h3F80_0000, 32'hFFBF_FFFF, 32'h0, 32'h0, 1'b0);
      queue_element(32'h8000_0000, 32'h0080_0000, 32'h8080_0000, 32'h0080_0000, 1'b1);
      queue_element(32'h3F80_0000, 32'h1F80_0000, 32'h0, 32'h0, 1'b0);  // g*g would underflow
      queue_element(32'h3F80_0000, 32'h5F80_0000, 32'h0, 32'h0, 1'b0);  // g*g would overflow
      queue_random(140);
      drain();

      set_registers(32'h3DCC_CCCD, 32'h3F4C_CCCD, 32'h3F7D_70A4, 32'h3727_C5AC, 32'h3C23_D70A);
      queue_random(150);
      drain();

      steady_flow = 1;
      set_registers(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      queue_random(150);
      drain();
      steady_flow = 0;

      set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_random(100);
      drain();

      set_registers(32'h7F7F_FFFF, 32'h3F80_0000, 32'h0000_0001, 32'h7F80_0000, 32'h8000_0000);
      queue_random(100);
      drain();

      set_registers($urandom, $urandom, $urandom, $urandom, $urandom);
      queue_random(100);
      drain();

      set_registers(32'h3A83_126F, 32'h3F66_6666, 32'h3F7F_BE77, 32'h322B_CC77, 32'h3DCC_CCCD);
      queue_random(150);
      drain();

      if (expected_updates.size() != 0) begin
         $error("%0d updates never arrived", expected_updates.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #(12 * 300000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

/* adam_weight_update_top.f */
+incdir+design
design/awu_pkg.sv
design/awu_sqrt.sv
design/awu_div.sv
design/adam_weight_update_top.sv
design/awu_checker.sv
test/adam_weight_update_top_test.sv
